>>> rtl/lslm_pkg.sv
`timescale 1ns / 1ps

package lslm_pkg;

	// Number of implemented layers (2 to 32)
	localparam int NUM_LAYERS = 32;
	localparam int IDX_W      = $clog2(NUM_LAYERS);
	localparam int LAYER_IN_W = 6;
	localparam int LAYER_W    = 5;
	localparam int MASK_W     = 32;

	// Opcodes
	localparam logic [2:0] OP_ACTIVATE   = 3'd0;
	localparam logic [2:0] OP_DEACTIVATE = 3'd1;
	localparam logic [2:0] OP_TOGGLE     = 3'd2;
	localparam logic [2:0] OP_GOTO       = 3'd3;
	localparam logic [2:0] OP_QUERY      = 3'd4;

	typedef struct packed {
		logic [2:0]            opcode;
		logic [LAYER_IN_W-1:0] layer;
		logic                  locking;
	} in_word_t;

	typedef struct packed {
		logic              is_event;
		logic [LAYER_W-1:0] event_layer;
		logic              event_state;
		logic              event_locking;
		logic              status;
		logic              layer_active;
		logic              layer_locked;
		logic [MASK_W-1:0] active_mask;
		logic [MASK_W-1:0] lock_mask;
		logic              last;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_WRITE,
		ST_STATUS
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic             latch;
		logic             wr_en;
		logic             wr_walk;
		logic [IDX_W-1:0] walk_idx;
		logic             status_en;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

>>> rtl/layer_state_lock_manager.sv
`timescale 1ns / 1ps

// Layer state and lock manager. Each accepted input word (opcode, layer,
// locking) yields zero or more event words, one per real change of the
// active or lock mask, followed by exactly one status word with last set.
// The block takes one word at a time: in_stall is high from acceptance until
// the status word is loaded into the output register. Activate, deactivate
// and toggle step through accept, write and status; query through accept and
// status; go-to-layer has the sequencer step one layer per cycle, while the
// output is free, from the highest layer down to 0, then write and status.
// An output stall holds the sequencer while a word waits in the output.
// default_layer may be written only while the block is idle.
module layer_state_lock_manager import lslm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_word_t           in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output out_word_t          out_word,
	input  logic               cfg_we,
	input  logic [LAYER_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	lslm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (in_word.opcode),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lslm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	// A locked layer is always active
	a_lock_in_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_word.lock_mask & ~out_word.active_mask) == '0))
		else $error("lock mask bit set without active bit");

	// The final word is never an event
	a_last_not_event: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.last) |-> !out_word.is_event)
		else $error("final word flagged as event");

	// The sequencer goes busy after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accept");

	// An event word carries no status flags
	a_event_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.is_event) |->
			(!out_word.status && !out_word.layer_active && !out_word.layer_locked))
		else $error("event word carries status flags");

endmodule

>>> rtl/lslm_ctrl.sv
`timescale 1ns / 1ps

module lslm_ctrl import lslm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] in_opcode,
	output logic       in_stall,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	// Hold state and walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// Sequence one input word: optional walk, a write for activate, deactivate, toggle and go-to, one status word
	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		cmd           = '0;
		cmd.walk_idx  = idx_q;
		in_stall      = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					idx_d     = IDX_W'(NUM_LAYERS - 1);
					if (in_opcode == OP_GOTO) begin
						state_d = ST_WALK;
					end else if (in_opcode == OP_ACTIVATE || in_opcode == OP_DEACTIVATE ||
							in_opcode == OP_TOGGLE) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_STATUS;
					end
				end
			end
			ST_WALK: begin
				if (sts.out_free) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_walk = 1'b1;
					if (idx_q == '0) begin
						state_d = ST_WRITE;
					end else begin
						idx_d = idx_q - 1'b1;
					end
				end
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					cmd.wr_en = 1'b1;
					state_d   = ST_STATUS;
				end
			end
			ST_STATUS: begin
				if (sts.out_free) begin
					cmd.status_en = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/lslm_dp.sv
`timescale 1ns / 1ps

module lslm_dp import lslm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  in_word_t           in_word,
	input  logic               cfg_we,
	input  logic [LAYER_W-1:0] cfg_wdata,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic               out_valid,
	input  logic               out_stall,
	output out_word_t          out_word
);

	logic [LAYER_W-1:0] def_q;
	in_word_t           op_q;
	logic [MASK_W-1:0]  act_q, lck_q;
	out_word_t          out_q;
	logic               out_valid_q;

	logic [LAYER_IN_W-1:0] wid;
	logic [LAYER_W-1:0]    wbit_idx;
	logic [MASK_W-1:0]     wbit;
	logic                  wid_ok, wid_def, id_ok, id_def;
	logic                  tgl_act, tgl_lkd, on, blocked, changed, ev_load;
	logic [MASK_W-1:0]     new_act, new_lck;
	logic                  q_act, q_lck;

	assign sts.out_free = !out_valid_q || !out_stall;

	// Pick the layer to write: walk index or the word's layer
	assign wid      = cmd.wr_walk ? LAYER_IN_W'(cmd.walk_idx) : op_q.layer;
	assign wbit_idx = wid[LAYER_W-1:0];
	assign wid_ok   = (wid < LAYER_IN_W'(NUM_LAYERS));
	assign wid_def  = (wid == {1'b0, def_q});
	assign wbit     = MASK_W'(1) << wbit_idx;

	// Toggle direction from the current flags
	assign tgl_act = act_q[wbit_idx] || wid_def;
	assign tgl_lkd = lck_q[wbit_idx] || wid_def;

	always_comb begin
		on = 1'b0;
		if (!cmd.wr_walk) begin
			case (op_q.opcode)
				OP_ACTIVATE: on = 1'b1;
				OP_GOTO:     on = 1'b1;
				OP_TOGGLE:   on = !(tgl_act && (!op_q.locking || tgl_lkd));
				default:     on = 1'b0;
			endcase
		end
	end

	// Apply one layer write
	assign blocked = !wid_ok || (wid_def && !on) ||
		(!op_q.locking && !on && ((lck_q & wbit) != '0));
	assign new_act = on ? (act_q | wbit) : (act_q & ~wbit);
	assign new_lck = !op_q.locking ? lck_q : (on ? (lck_q | wbit) : (lck_q & ~wbit));
	assign changed = !blocked && ((new_act != act_q) || (new_lck != lck_q));
	assign ev_load = cmd.wr_en && changed;

	// Query flags for the status word
	assign id_ok  = (op_q.layer < LAYER_IN_W'(NUM_LAYERS));
	assign id_def = (op_q.layer == {1'b0, def_q});
	assign q_act  = id_ok && (act_q[op_q.layer[LAYER_W-1:0]] || id_def);
	assign q_lck  = id_ok && (lck_q[op_q.layer[LAYER_W-1:0]] || id_def);

	// Hold config, masks and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_q       <= '0;
			act_q       <= '0;
			lck_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				def_q <= cfg_wdata;
			end
			if (ev_load) begin
				act_q <= new_act;
				lck_q <= new_lck;
			end
			if (ev_load || cmd.status_en) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the input word and build output words
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= in_word;
		end
		if (ev_load) begin
			out_q               <= '0;
			out_q.is_event      <= 1'b1;
			out_q.event_layer   <= wbit_idx;
			out_q.event_state   <= on;
			out_q.event_locking <= op_q.locking;
			out_q.active_mask   <= new_act;
			out_q.lock_mask     <= new_lck;
		end else if (cmd.status_en) begin
			out_q              <= '0;
			out_q.status       <= !id_ok;
			out_q.layer_active <= q_act;
			out_q.layer_locked <= q_lck;
			out_q.active_mask  <= act_q;
			out_q.lock_mask    <= lck_q;
			out_q.last         <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule
